### rtl/bq_pkg.sv
`default_nettype none
package bq_pkg;

  // default field widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 20;
  localparam int DELAY_W    = 24;

  // fixed-point fraction bits: coefficients Q3.16, delays Q15.8
  localparam int COEF_FRAC  = 16;
  localparam int DELAY_FRAC = 8;
  localparam int ACC_FRAC   = COEF_FRAC + DELAY_FRAC;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd5;

  // accumulator control from the sequencer
  typedef struct packed {
    logic load;
    logic add;
    logic sub;
  } mac_ctrl_t;

endpackage
`default_nettype wire

### rtl/bq_if.sv
`default_nettype none
// input sample channel
interface bq_in_if #(parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_W);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// filtered sample channel
interface bq_out_if #(parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_W);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;
  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface
`default_nettype wire

### rtl/bq_mac.sv
`default_nettype none
module bq_mac #(
  parameter int COEF_WIDTH  = bq_pkg::COEF_W,
  parameter int DELAY_WIDTH = bq_pkg::DELAY_W,
  parameter int ACC_WIDTH   = bq_pkg::COEF_W + bq_pkg::DELAY_W + 3
) (
  input  wire logic                          clk,
  input  wire bq_pkg::mac_ctrl_t             ctrl,
  input  wire logic signed [COEF_WIDTH-1:0]  coef,
  input  wire logic signed [DELAY_WIDTH-1:0] delay,
  input  wire logic signed [ACC_WIDTH-1:0]   init,
  output logic signed [ACC_WIDTH-1:0]        acc
);
  import bq_pkg::*;

  localparam int PROD_W = COEF_WIDTH + DELAY_WIDTH;

  logic signed [PROD_W-1:0]    prod_r;
  logic signed [ACC_WIDTH-1:0] prod_ext;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic signed [ACC_WIDTH-1:0] acc_nxt;

  // one product per cycle, registered before the accumulator
  always_ff @(posedge clk) begin
    prod_r <= coef * delay;
  end

  assign prod_ext = {{(ACC_WIDTH-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // accumulator: load, add or subtract the last product
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.load) begin
      acc_nxt = init;
    end else if (ctrl.add) begin
      acc_nxt = acc_r + prod_ext;
    end else if (ctrl.sub) begin
      acc_nxt = acc_r - prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

### rtl/biquad_lowpass_filter.sv
// Biquad low-pass filter, direct form II, one shared multiplier.
// Input ready only while idle: a new word is taken once the last has left for the output
// register. A filtered word's five products go one by one through the single multiplier
// and its accumulator. Reset (rst_n low, synchronous) clears the config, the state, out
// valid and both delays, leaving the filter disabled (words pass straight through).
`default_nettype none
module biquad_lowpass_filter #(
  parameter int SAMPLE_WIDTH = bq_pkg::SAMPLE_W,
  parameter int COEF_WIDTH   = bq_pkg::COEF_W,
  parameter int DELAY_WIDTH  = bq_pkg::DELAY_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  bq_in_if.sink                             in_ch,
  bq_out_if.source                          out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [bq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]        cfg_data
);
  import bq_pkg::*;

  localparam int WIDE_A  = SAMPLE_WIDTH + ACC_FRAC;
  localparam int WIDE_B  = COEF_WIDTH + DELAY_WIDTH;
  localparam int ACC_W   = ((WIDE_A > WIDE_B) ? WIDE_A : WIDE_B) + 3;
  localparam int WTOP_W  = ACC_W - COEF_FRAC - DELAY_WIDTH + 1;
  localparam int YTOP_W  = ACC_W - ACC_FRAC - SAMPLE_WIDTH + 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FB1  = 4'd1;
  localparam logic [3:0] ST_FB2  = 4'd2;
  localparam logic [3:0] ST_FB3  = 4'd3;
  localparam logic [3:0] ST_WSAT = 4'd4;
  localparam logic [3:0] ST_FF1  = 4'd5;
  localparam logic [3:0] ST_FF2  = 4'd6;
  localparam logic [3:0] ST_FF3  = 4'd7;
  localparam logic [3:0] ST_FF4  = 4'd8;
  localparam logic [3:0] ST_YSAT = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0] state_r, state_nxt;

  logic                          enable_r;
  logic signed [COEF_WIDTH-1:0]  b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [DELAY_WIDTH-1:0] d1_r, d2_r;
  logic signed [DELAY_WIDTH-1:0] w_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r;
  logic                          clip_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                          out_clip_r;

  logic                          in_acc;
  logic                          out_load;
  mac_ctrl_t                     mac_ctrl;
  logic signed [COEF_WIDTH-1:0]  mul_coef;
  logic signed [DELAY_WIDTH-1:0] mul_delay;
  logic signed [ACC_W-1:0]       mac_init;
  logic signed [ACC_W-1:0]       acc;

  logic [WTOP_W-1:0]             w_top;
  logic                          w_ovf;
  logic signed [DELAY_WIDTH-1:0] w_sat;
  logic [YTOP_W-1:0]             y_top;
  logic                          y_ovf;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      b0_r     <= '0;
      b1_r     <= '0;
      b2_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: enable_r <= cfg_data[0];
        REG_B0:     b0_r     <= cfg_data;
        REG_B1:     b1_r     <= cfg_data;
        REG_B2:     b2_r     <= cfg_data;
        REG_A1:     a1_r     <= cfg_data;
        REG_A2:     a2_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // operand select and accumulator control per step
  always_comb begin
    mul_coef  = a1_r;
    mul_delay = d1_r;
    mac_ctrl  = '0;
    mac_init  = {{(ACC_W-SAMPLE_WIDTH-ACC_FRAC){in_ch.sample_in[SAMPLE_WIDTH-1]}},
                 in_ch.sample_in, {ACC_FRAC{1'b0}}} | (ACC_W'(1) << (COEF_FRAC - 1));
    case (state_r)
      ST_IDLE: mac_ctrl.load = in_acc && enable_r;
      ST_FB1: begin
        mul_coef  = a1_r;
        mul_delay = d1_r;
      end
      ST_FB2: begin
        mul_coef     = a2_r;
        mul_delay    = d2_r;
        mac_ctrl.sub = 1'b1;
      end
      ST_FB3:  mac_ctrl.sub = 1'b1;
      ST_WSAT: begin
        // start output sum with its rounding half
        mac_init      = ACC_W'(1) << (ACC_FRAC - 1);
        mac_ctrl.load = 1'b1;
      end
      ST_FF1: begin
        mul_coef  = b0_r;
        mul_delay = w_r;
      end
      ST_FF2: begin
        mul_coef     = b1_r;
        mul_delay    = d1_r;
        mac_ctrl.add = 1'b1;
      end
      ST_FF3: begin
        mul_coef     = b2_r;
        mul_delay    = d2_r;
        mac_ctrl.add = 1'b1;
      end
      ST_FF4:  mac_ctrl.add = 1'b1;
      default: ;
    endcase
  end

  bq_mac #(
    .COEF_WIDTH  (COEF_WIDTH),
    .DELAY_WIDTH (DELAY_WIDTH),
    .ACC_WIDTH   (ACC_W)
  ) u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .coef  (mul_coef),
    .delay (mul_delay),
    .init  (mac_init),
    .acc   (acc)
  );

  // round-and-saturate of w: bits above the delay range must match the sign
  assign w_top = acc[ACC_W-1 -: WTOP_W];
  assign w_ovf = !((&w_top) || !(|w_top));
  assign w_sat = w_ovf ? (acc[ACC_W-1] ? {1'b1, {(DELAY_WIDTH-1){1'b0}}}
                                       : {1'b0, {(DELAY_WIDTH-1){1'b1}}})
                       : acc[COEF_FRAC +: DELAY_WIDTH];

  // round-and-saturate of the output sample
  assign y_top = acc[ACC_W-1 -: YTOP_W];
  assign y_ovf = !((&y_top) || !(|y_top));
  assign y_sat = y_ovf ? (acc[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}})
                       : acc[ACC_FRAC +: SAMPLE_WIDTH];

  // step sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = enable_r ? ST_FB1 : ST_DONE;
      end
      ST_FB1:  state_nxt = ST_FB2;
      ST_FB2:  state_nxt = ST_FB3;
      ST_FB3:  state_nxt = ST_WSAT;
      ST_WSAT: state_nxt = ST_FF1;
      ST_FF1:  state_nxt = ST_FF2;
      ST_FF2:  state_nxt = ST_FF3;
      ST_FF3:  state_nxt = ST_FF4;
      ST_FF4:  state_nxt = ST_YSAT;
      ST_YSAT: state_nxt = ST_DONE;
      ST_DONE: if (out_load) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // delay line, only moved by a filtered word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (state_r == ST_YSAT) begin
      d2_r <= d1_r;
      d1_r <= w_r;
    end
  end

  // working values of the current word
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && !enable_r) begin
      y_r    <= in_ch.sample_in;
      clip_r <= 1'b0;
    end else if (state_r == ST_WSAT) begin
      w_r    <= w_sat;
      clip_r <= w_ovf;
    end else if (state_r == ST_YSAT) begin
      y_r    <= y_sat;
      clip_r <= clip_r | y_ovf;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= y_r;
      out_clip_r   <= clip_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.clipped    = out_clip_r;

endmodule
`default_nettype wire
